[sv/cdq_pkg.sv]
package cdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_OUT,
        S_LIST_RD,
        S_LIST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    wr_front;
        logic    wr_back;
        logic    pop_front;
        logic    pop_back;
        logic    list_first;
        logic    list_next;
        logic    load_mem;
        logic    load_code;
        t_status code;
        logic    out_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_more;
    } t_stat;

endpackage

[sv/cdq_ctrl.sv]
module cdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_opcode,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cdq_pkg::t_stat i_stat,
    output cdq_pkg::t_cmd  o_cmd
);
    import cdq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.code  = ST_OK;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            o_cmd.load_code = 1'b1;
                            n_state         = S_OUT;
                            if (i_stat.full) begin
                                o_cmd.code = ST_OVER;
                            end else begin
                                o_cmd.wr_front = (i_opcode == OP_PUSH_FRONT);
                                o_cmd.wr_back  = (i_opcode == OP_PUSH_BACK);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (i_stat.empty) begin
                                o_cmd.load_code = 1'b1;
                                o_cmd.code      = ST_UNDER;
                                n_state         = S_OUT;
                            end else begin
                                o_cmd.pop_front = (i_opcode == OP_POP_FRONT);
                                o_cmd.pop_back  = (i_opcode == OP_POP_BACK);
                                n_state         = S_RD;
                            end
                        end
                        OP_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.load_code = 1'b1;
                                o_cmd.code      = ST_UNDER;
                                n_state         = S_OUT;
                            end else begin
                                o_cmd.list_first = 1'b1;
                                n_state          = S_LIST_RD;
                            end
                        end
                        default: begin
                            // drop unused opcodes
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.load_mem = 1'b1;
                o_cmd.out_last = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST_RD: begin
                o_cmd.load_mem = 1'b1;
                o_cmd.out_last = !i_stat.list_more;
                n_state        = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.list_more) begin
                        o_cmd.list_next = 1'b1;
                        n_state         = S_LIST_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/cdq_dpath.sv]
module cdq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdq_pkg::t_cmd       i_cmd,
    input  logic signed [31:0]  i_value,
    output cdq_pkg::t_stat      o_stat,
    output logic signed [31:0]  o_elem_value,
    output logic [1:0]          o_status,
    output logic                o_last
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    logic [AW-1:0] r_front;
    logic [AW-1:0] n_front;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] idx_inc;

    // ring slot of front + off, with off below DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign idx_inc   = CW'(r_idx) + CW'(1);

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.list_more = (idx_inc < r_count);

    always_comb begin
        wr_addr = i_cmd.wr_front ? front_dec : slot(r_front, r_count);
        if (i_cmd.pop_back) begin
            rd_addr = slot(r_front, r_count - CW'(1));
        end else if (i_cmd.list_next) begin
            rd_addr = slot(r_front, idx_inc);
        end else begin
            rd_addr = r_front;
        end
    end

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_idx   = r_idx;
        if (i_cmd.wr_front) begin
            n_front = front_dec;
        end
        if (i_cmd.pop_front) begin
            n_front = slot(r_front, CW'(1));
        end
        if (i_cmd.wr_front || i_cmd.wr_back) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.pop_front || i_cmd.pop_back) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.list_first) begin
            n_idx = '0;
        end
        if (i_cmd.list_next) begin
            n_idx = idx_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_front || i_cmd.wr_back) begin
            r_mem[wr_addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_front || i_cmd.pop_back || i_cmd.list_first || i_cmd.list_next) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mem) begin
            o_elem_value <= r_rd_data;
            o_status     <= ST_OK;
            o_last       <= i_cmd.out_last;
        end else if (i_cmd.load_code) begin
            o_elem_value <= '0;
            o_status     <= i_cmd.code;
            o_last       <= 1'b1;
        end
    end

endmodule

[sv/circular_list_deque.sv]
// Push: result valid in the cycle after the item is accepted (registered output).
// Pop: the memory read is registered (S_RD), then the result goes to the output registers (S_OUT).
// List: after accept, each stored element is read (S_LIST_RD), then presented (S_LIST_OUT),
// where output stalls hold it. Full or empty cases answer like a push.
// Only one result is in flight at a time; a new item waits until it is taken.
// Reset clears front index, element count and controller; the store keeps its contents.
module circular_list_deque #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_elem_value,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import cdq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .o_stat       (stat),
        .o_elem_value (o_elem_value),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
